// File: hdl/prs_pkg.sv
// Package for the power rail sequencer: codes, field widths, phase encoding
// and the structs passed between the pipeline stages. No dependencies.
package prs_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int COUNT_BITS = 16;
  localparam int CMP_BITS   = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam int WIDE_BITS  = (CMP_BITS > COUNT_BITS) ? CMP_BITS : COUNT_BITS;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [CFG_BITS-1:0]   CFG_RESET_VALUE = CFG_BITS'(100);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2,
    OP_RECOVER = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_STARTUP_TIMEOUT = 1'b0,
    CFG_RECOVERY_DELAY  = 1'b1
  } cfg_index_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  localparam logic [1:0] FAULT_NONE        = 2'd0;
  localparam logic [1:0] FAULT_TIMEOUT     = 2'd1;
  localparam logic [1:0] FAULT_OVERCURRENT = 2'd2;

  localparam logic [2:0] SEQ_OFF        = 3'd0;
  localparam logic [2:0] SEQ_STARTING   = 3'd1;
  localparam logic [2:0] SEQ_ON         = 3'd2;
  localparam logic [2:0] SEQ_FAULT      = 3'd3;
  localparam logic [2:0] SEQ_RECOVERING = 3'd4;

  typedef enum logic [4:0] {
    PH_OFF        = 5'b00001,
    PH_STARTING   = 5'b00010,
    PH_ON         = 5'b00100,
    PH_FAULT      = 5'b01000,
    PH_RECOVERING = 5'b10000
  } phase_t;

  typedef struct packed {
    op_t  operation;
    logic pgood;
    logic overcurrent;
  } item_t;

  typedef struct packed {
    logic                  status;
    logic [2:0]            seq_state;
    logic [1:0]            fault_code;
    logic [COUNT_BITS-1:0] tick_count;
  } result_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_OFF:        code = SEQ_OFF;
      PH_STARTING:   code = SEQ_STARTING;
      PH_ON:         code = SEQ_ON;
      PH_FAULT:      code = SEQ_FAULT;
      PH_RECOVERING: code = SEQ_RECOVERING;
      default:       code = SEQ_OFF;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/power_rail_sequencer_top.sv
// Top level of the power rail sequencer: input register, sequencer core and
// result register. Depends on prs_pkg, prs_in_stage, prs_core, prs_out_stage.
//
// The sequencer takes one request per clock cycle and gives one result per
// request, in order, after it passes the input register and then the result
// register, with the whole state update done in the single logic stage
// between them. Requests keep flowing while a result waits, until both
// registers are full. The startup timeout and recovery delay registers come
// out of reset at 100; the user must write them through cfg_we only while no
// request is in flight, as the block itself does not enforce it.
module power_rail_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [prs_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    operation,
  input  logic                          pgood,
  input  logic                          overcurrent,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          status,
  output logic [2:0]                    seq_state,
  output logic [1:0]                    fault_code,
  output logic [prs_pkg::COUNT_BITS-1:0] tick_count
);

  prs_pkg::item_t   req_item;
  prs_pkg::item_t   item;
  prs_pkg::result_t core_result;
  prs_pkg::result_t held_result;
  logic             item_valid;
  logic             can_load;
  logic             fire;

  assign req_item.operation   = prs_pkg::op_t'(operation);
  assign req_item.pgood       = pgood;
  assign req_item.overcurrent = overcurrent;

  assign fire = item_valid && can_load;

  prs_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .advance   (fire),
    .valid     (item_valid),
    .item      (item)
  );

  prs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (prs_pkg::cfg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .result    (core_result)
  );

  prs_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (fire),
    .load_result (core_result),
    .can_load    (can_load),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .result      (held_result)
  );

  assign status     = held_result.status;
  assign seq_state  = held_result.seq_state;
  assign fault_code = held_result.fault_code;
  assign tick_count = held_result.tick_count;

endmodule

// File: hdl/prs_in_stage.sv
// Input register of the power rail sequencer: holds one accepted request
// until the core consumes it. Depends on prs_pkg.
module prs_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  prs_pkg::item_t req_item,
  input  logic           advance,
  output logic           valid,
  output prs_pkg::item_t item
);

  assign req_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_ready) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req_item;
    end
  end

`ifndef SYNTHESIS
  a_advance_needs_item: assert property (@(posedge clk) disable iff (rst)
    advance |-> valid)
    else $error("core consumed a request from an empty input register");
`endif

endmodule

// File: hdl/prs_core.sv
// Sequencer core: configuration registers, phase, fault and timer state and
// the next-state logic for one request per cycle in which fire is high. Depends on prs_pkg.
module prs_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  prs_pkg::cfg_index_t           cfg_index,
  input  logic [prs_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          fire,
  input  prs_pkg::item_t                item,
  output prs_pkg::result_t              result
);

  logic [prs_pkg::CFG_BITS-1:0]   startup_timeout;
  logic [prs_pkg::CFG_BITS-1:0]   recovery_delay;
  prs_pkg::phase_t                phase;
  prs_pkg::phase_t                phase_next;
  logic [1:0]                     fault_reg;
  logic [1:0]                     fault_reg_next;
  logic [prs_pkg::TIMER_BITS-1:0] timer;
  logic [prs_pkg::TIMER_BITS-1:0] timer_next;
  logic [prs_pkg::TIMER_BITS-1:0] timer_inc;
  logic                           status;
  logic                           startup_expired;
  logic                           recovery_expired;
  logic [prs_pkg::WIDE_BITS-1:0]  timer_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      startup_timeout <= prs_pkg::CFG_RESET_VALUE;
      recovery_delay  <= prs_pkg::CFG_RESET_VALUE;
    end else if (cfg_we) begin
      case (cfg_index)
        prs_pkg::CFG_STARTUP_TIMEOUT: startup_timeout <= cfg_data;
        prs_pkg::CFG_RECOVERY_DELAY:  recovery_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    timer_inc = timer;
    if ((phase == prs_pkg::PH_STARTING || phase == prs_pkg::PH_RECOVERING)
        && timer != prs_pkg::TIMER_MAX) begin
      timer_inc = timer + prs_pkg::TIMER_BITS'(1);
    end
    startup_expired  = prs_pkg::CMP_BITS'(timer_inc) >= prs_pkg::CMP_BITS'(startup_timeout);
    recovery_expired = prs_pkg::CMP_BITS'(timer_inc) >= prs_pkg::CMP_BITS'(recovery_delay);
  end

  always_comb begin
    phase_next     = phase;
    fault_reg_next = fault_reg;
    timer_next     = timer;
    status         = prs_pkg::STATUS_OK;
    case (item.operation)
      prs_pkg::OP_TICK: begin
        timer_next = timer_inc;
        case (phase)
          prs_pkg::PH_STARTING: begin
            if (item.pgood) begin
              phase_next = prs_pkg::PH_ON;
              timer_next = '0;
            end else if (startup_expired) begin
              phase_next     = prs_pkg::PH_FAULT;
              fault_reg_next = prs_pkg::FAULT_TIMEOUT;
              timer_next     = '0;
            end
          end
          prs_pkg::PH_ON: begin
            if (item.overcurrent) begin
              phase_next     = prs_pkg::PH_FAULT;
              fault_reg_next = prs_pkg::FAULT_OVERCURRENT;
              timer_next     = '0;
            end
          end
          prs_pkg::PH_RECOVERING: begin
            if (recovery_expired) begin
              phase_next = prs_pkg::PH_OFF;
              timer_next = '0;
            end
          end
          default: ;
        endcase
      end
      prs_pkg::OP_ENABLE: begin
        if (phase == prs_pkg::PH_OFF) begin
          phase_next     = prs_pkg::PH_STARTING;
          fault_reg_next = prs_pkg::FAULT_NONE;
          timer_next     = '0;
        end else begin
          status = prs_pkg::STATUS_INVALID;
        end
      end
      prs_pkg::OP_DISABLE: begin
        if (phase == prs_pkg::PH_ON) begin
          phase_next = prs_pkg::PH_OFF;
          timer_next = '0;
        end else begin
          status = prs_pkg::STATUS_INVALID;
        end
      end
      prs_pkg::OP_RECOVER: begin
        if (phase == prs_pkg::PH_FAULT) begin
          phase_next = prs_pkg::PH_RECOVERING;
          timer_next = '0;
        end else begin
          status = prs_pkg::STATUS_INVALID;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= prs_pkg::PH_OFF;
      fault_reg <= prs_pkg::FAULT_NONE;
      timer     <= '0;
    end else if (fire) begin
      phase     <= phase_next;
      fault_reg <= fault_reg_next;
      timer     <= timer_next;
    end
  end

  always_comb begin
    timer_wide        = prs_pkg::WIDE_BITS'(timer_next);
    result.status     = status;
    result.seq_state  = prs_pkg::phase_code(phase_next);
    result.fault_code = fault_reg_next;
    result.tick_count = timer_wide[prs_pkg::COUNT_BITS-1:0];
  end

`ifndef SYNTHESIS
  a_timer_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !(phase == prs_pkg::PH_STARTING || phase == prs_pkg::PH_RECOVERING) |-> timer == '0)
    else $error("timer is nonzero outside starting and recovering");

  a_invalid_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (fire && status == prs_pkg::STATUS_INVALID) |=>
      (phase == $past(phase) && fault_reg == $past(fault_reg) && timer == $past(timer)))
    else $error("an invalid request changed the sequencer state");

  a_fault_has_code: assert property (@(posedge clk) disable iff (rst)
    (phase == prs_pkg::PH_FAULT) |-> fault_reg != prs_pkg::FAULT_NONE)
    else $error("fault phase without a fault code");
`endif

endmodule

// File: hdl/prs_out_stage.sv
// Result register of the power rail sequencer: holds one result until the
// consumer takes it, loading a new one in the same cycle. Depends on prs_pkg.
module prs_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  prs_pkg::result_t load_result,
  output logic             can_load,
  output logic             res_valid,
  input  logic             res_ready,
  output prs_pkg::result_t result
);

  assign can_load = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (can_load) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result <= load_result;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> can_load)
    else $error("result register loaded while holding an untaken result");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for power_rail_sequencer_top: directed table, then random
// requests and a run at the largest limits, checked against a behavioral predictor
// of the sequencer state machine. Depends on prs_pkg and the sequencer RTL.
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 166;
  localparam int SEND_IDLE [3] = '{37, 84, 0};
  localparam int RECV_IDLE [3] = '{84, 37, 0};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    prs_pkg::item_t      req;
    prs_pkg::cfg_index_t cfg_idx;
    logic [15:0]         cfg_value;
    logic                pinned;
    prs_pkg::result_t    res;
  } plan_row_t;

  typedef struct packed {
    logic             pinned;
    prs_pkg::result_t res;
  } pin_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [prs_pkg::CFG_BITS-1:0] cfg_data;
  logic req_valid;
  logic req_ready;
  logic [1:0] operation;
  logic pgood;
  logic overcurrent;
  logic res_valid;
  logic res_ready;
  logic status;
  logic [2:0] seq_state;
  logic [1:0] fault_code;
  logic [prs_pkg::COUNT_BITS-1:0] tick_count;

  logic [2:0] rail_phase;
  logic [1:0] rail_fault;
  logic [prs_pkg::TIMER_BITS-1:0] rail_timer;
  logic [prs_pkg::CFG_BITS-1:0] startup_limit;
  logic [prs_pkg::CFG_BITS-1:0] recovery_limit;

  prs_pkg::result_t expected_q[$];
  pin_t pin_q[$];
  int mismatches;
  int stalled_cycles;
  int send_idle_pct;
  int recv_idle_pct;

  plan_row_t plan [0:28] = '{
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b0, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_OFF, prs_pkg::FAULT_NONE, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_DISABLE, 1'b1, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_INVALID, prs_pkg::SEQ_OFF, prs_pkg::FAULT_NONE, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_RECOVER, 1'b0, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_INVALID, prs_pkg::SEQ_OFF, prs_pkg::FAULT_NONE, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_ENABLE, 1'b0, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_STARTING, prs_pkg::FAULT_NONE, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_ENABLE, 1'b1, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_INVALID, prs_pkg::SEQ_STARTING, prs_pkg::FAULT_NONE, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_DISABLE, 1'b1, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_RECOVER, 1'b0, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b0, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_STARTING, prs_pkg::FAULT_NONE, 16'd1}},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b1, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_ON, prs_pkg::FAULT_NONE, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b1, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_ENABLE, 1'b0, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_INVALID, prs_pkg::SEQ_ON, prs_pkg::FAULT_NONE, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_RECOVER, 1'b1, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b0, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_FAULT, prs_pkg::FAULT_OVERCURRENT, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b1, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_ENABLE, 1'b1, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_INVALID, prs_pkg::SEQ_FAULT, prs_pkg::FAULT_OVERCURRENT, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_DISABLE, 1'b0, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_RECOVER, 1'b0, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_RECOVERING, prs_pkg::FAULT_OVERCURRENT, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_RECOVER, 1'b1, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b1, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_RECOVERING, prs_pkg::FAULT_OVERCURRENT, 16'd1}},
    '{ROW_CFG, '{prs_pkg::OP_TICK, 1'b0, 1'b0}, prs_pkg::CFG_RECOVERY_DELAY, 16'd1, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b0, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_OFF, prs_pkg::FAULT_OVERCURRENT, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_ENABLE, 1'b0, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_STARTING, prs_pkg::FAULT_NONE, 16'd0}},
    '{ROW_CFG, '{prs_pkg::OP_TICK, 1'b0, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd1, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b0, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_FAULT, prs_pkg::FAULT_TIMEOUT, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_RECOVER, 1'b1, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_RECOVERING, prs_pkg::FAULT_TIMEOUT, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b0, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_OFF, prs_pkg::FAULT_TIMEOUT, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_ENABLE, 1'b1, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b0,
      '0},
    '{ROW_REQ, '{prs_pkg::OP_TICK, 1'b1, 1'b0}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_ON, prs_pkg::FAULT_NONE, 16'd0}},
    '{ROW_REQ, '{prs_pkg::OP_DISABLE, 1'b0, 1'b1}, prs_pkg::CFG_STARTUP_TIMEOUT, 16'd0, 1'b1,
      '{prs_pkg::STATUS_OK, prs_pkg::SEQ_OFF, prs_pkg::FAULT_NONE, 16'd0}}
  };

  power_rail_sequencer_top dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic prs_pkg::result_t advance_sequencer(input prs_pkg::item_t req);
    prs_pkg::result_t r;
    r.status = prs_pkg::STATUS_OK;
    case (req.operation)
      prs_pkg::OP_TICK: begin
        if ((rail_phase == prs_pkg::SEQ_STARTING || rail_phase == prs_pkg::SEQ_RECOVERING) &&
            rail_timer != prs_pkg::TIMER_MAX) begin
          rail_timer = rail_timer + 1'b1;
        end
        if (rail_phase == prs_pkg::SEQ_STARTING) begin
          if (req.pgood) begin
            rail_phase = prs_pkg::SEQ_ON;
            rail_timer = '0;
          end else if (rail_timer >= startup_limit) begin
            rail_phase = prs_pkg::SEQ_FAULT;
            rail_fault = prs_pkg::FAULT_TIMEOUT;
            rail_timer = '0;
          end
        end else if (rail_phase == prs_pkg::SEQ_ON) begin
          if (req.overcurrent) begin
            rail_phase = prs_pkg::SEQ_FAULT;
            rail_fault = prs_pkg::FAULT_OVERCURRENT;
            rail_timer = '0;
          end
        end else if (rail_phase == prs_pkg::SEQ_RECOVERING) begin
          if (rail_timer >= recovery_limit) begin
            rail_phase = prs_pkg::SEQ_OFF;
            rail_timer = '0;
          end
        end
      end
      prs_pkg::OP_ENABLE: begin
        if (rail_phase == prs_pkg::SEQ_OFF) begin
          rail_phase = prs_pkg::SEQ_STARTING;
          rail_fault = prs_pkg::FAULT_NONE;
          rail_timer = '0;
        end else begin
          r.status = prs_pkg::STATUS_INVALID;
        end
      end
      prs_pkg::OP_DISABLE: begin
        if (rail_phase == prs_pkg::SEQ_ON) begin
          rail_phase = prs_pkg::SEQ_OFF;
          rail_timer = '0;
        end else begin
          r.status = prs_pkg::STATUS_INVALID;
        end
      end
      default: begin
        if (rail_phase == prs_pkg::SEQ_FAULT) begin
          rail_phase = prs_pkg::SEQ_RECOVERING;
          rail_timer = '0;
        end else begin
          r.status = prs_pkg::STATUS_INVALID;
        end
      end
    endcase
    r.seq_state = rail_phase;
    r.fault_code = rail_fault;
    r.tick_count = rail_timer;
    return r;
  endfunction

  // Mostly requests that make sense in the current state, with some noise mixed in.
  function automatic prs_pkg::item_t pick_request();
    prs_pkg::item_t it;
    it.operation = prs_pkg::OP_TICK;
    it.pgood = 1'($urandom_range(1));
    it.overcurrent = 1'($urandom_range(1));
    if ($urandom_range(99) < 20) begin
      it.operation = prs_pkg::op_t'($urandom_range(3));
    end else begin
      case (rail_phase)
        prs_pkg::SEQ_OFF: begin
          if ($urandom_range(3) != 0) it.operation = prs_pkg::OP_ENABLE;
        end
        prs_pkg::SEQ_STARTING: begin
          it.pgood = ($urandom_range(99) < 15);
        end
        prs_pkg::SEQ_ON: begin
          it.overcurrent = ($urandom_range(99) < 10);
          if ($urandom_range(99) < 15) it.operation = prs_pkg::OP_DISABLE;
        end
        prs_pkg::SEQ_FAULT: begin
          if ($urandom_range(3) != 0) it.operation = prs_pkg::OP_RECOVER;
        end
        default: begin
        end
      endcase
    end
    return it;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_request(input prs_pkg::item_t req, input logic pinned,
                              input prs_pkg::result_t pin_res);
    pin_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    entry.pinned = pinned;
    entry.res = pin_res;
    pin_q.push_back(entry);
    req_valid <= 1'b1;
    operation <= req.operation;
    pgood <= req.pgood;
    overcurrent <= req.overcurrent;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_plain(input prs_pkg::op_t op, input logic pg, input logic oc);
    prs_pkg::item_t it;
    it.operation = op;
    it.pgood = pg;
    it.overcurrent = oc;
    send_request(it, 1'b0, '0);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_limit(input prs_pkg::cfg_index_t idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == prs_pkg::CFG_STARTUP_TIMEOUT) begin
      startup_limit = value;
    end else begin
      recovery_limit = value;
    end
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : monitor
    pin_t pin;
    prs_pkg::item_t seen;
    prs_pkg::result_t predicted;
    prs_pkg::result_t want;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got state %0d count %0d",
                   $time, seq_state, tick_count);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 16'(want.status), 16'(status));
          check_field("seq_state", 16'(want.seq_state), 16'(seq_state));
          check_field("fault_code", 16'(want.fault_code), 16'(fault_code));
          check_field("tick_count", want.tick_count, tick_count);
        end
      end
      if (req_valid && req_ready) begin
        pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        seen.operation = prs_pkg::op_t'(operation);
        seen.pgood = pgood;
        seen.overcurrent = overcurrent;
        predicted = advance_sequencer(seen);
        expected_q.push_back(pin.pinned ? pin.res : predicted);
      end
      if ((req_valid && req_ready) || (res_valid && res_ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = prs_pkg::CFG_STARTUP_TIMEOUT;
    cfg_data = '0;
    req_valid = 1'b0;
    operation = prs_pkg::OP_TICK;
    pgood = 1'b0;
    overcurrent = 1'b0;
    res_ready = 1'b0;
    mismatches = 0;
    stalled_cycles = 0;
    rail_phase = prs_pkg::SEQ_OFF;
    rail_fault = prs_pkg::FAULT_NONE;
    rail_timer = '0;
    startup_limit = prs_pkg::CFG_RESET_VALUE;
    recovery_limit = prs_pkg::CFG_RESET_VALUE;
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_limit(plan[i].cfg_idx, plan[i].cfg_value);
      end else begin
        send_request(plan[i].req, plan[i].pinned, plan[i].res);
      end
    end

    for (int p = 0; p < 3; p++) begin
      wait_idle();
      send_idle_pct = SEND_IDLE[p];
      recv_idle_pct = RECV_IDLE[p];
      write_limit(prs_pkg::CFG_STARTUP_TIMEOUT, 16'($urandom_range(1, 10)));
      write_limit(prs_pkg::CFG_RECOVERY_DELAY, 16'($urandom_range(1, 10)));
      repeat (RANDOM_PER_PHASE) send_request(pick_request(), 1'b0, '0);
    end

    // Walk back to off, then step through every phase with both limits at their largest.
    while (rail_phase != prs_pkg::SEQ_OFF) begin
      case (rail_phase)
        prs_pkg::SEQ_ON: send_plain(prs_pkg::OP_DISABLE, 1'b0, 1'b0);
        prs_pkg::SEQ_FAULT: send_plain(prs_pkg::OP_RECOVER, 1'b0, 1'b0);
        default: send_plain(prs_pkg::OP_TICK, 1'b1, 1'b0);
      endcase
    end
    wait_idle();
    write_limit(prs_pkg::CFG_STARTUP_TIMEOUT, 16'hFFFF);
    write_limit(prs_pkg::CFG_RECOVERY_DELAY, 16'hFFFF);
    send_plain(prs_pkg::OP_ENABLE, 1'b0, 1'b0);
    repeat (8) send_plain(prs_pkg::OP_TICK, 1'b0, 1'($urandom_range(1)));
    send_plain(prs_pkg::OP_TICK, 1'b1, 1'b0);
    send_plain(prs_pkg::OP_TICK, 1'b0, 1'b1);
    send_plain(prs_pkg::OP_RECOVER, 1'b0, 1'b0);
    repeat (8) send_plain(prs_pkg::OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
    wait_idle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
